/* hw/rtl/bmhq_pkg.sv */
// shared types, codes and defaults of the binary max-heap queue
`timescale 1ns / 1ps
`default_nettype none

package bmhq_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;

  localparam int FIELD_W  = 32;  // value, removed_value and top_value fields
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = 7;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept_ins;    // take an insert: store value as the moving entry
    logic accept_rem;    // take a remove: capture the root, drop the count
    logic refuse_full;
    logic refuse_empty;
    logic up_read;       // read the parent of the hole
    logic up_move;       // parent moves down into the hole
    logic last_read;     // read the last entry
    logic last_take;     // last entry becomes the moving entry, hole at root
    logic dn_read;       // read both children of the hole
    logic dn_move;       // larger child moves up into the hole
    logic place;         // moving entry is written into the hole
    logic finish;        // load the result register
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_zero;
    logic left_ok;
    logic up_greater;
    logic dn_greater;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/bmhq_req_if.sv */
// request channel: operation and value with valid/ready
`timescale 1ns / 1ps
`default_nettype none

interface bmhq_req_if;
  logic                               valid;
  logic                               ready;
  logic                               operation;
  logic signed [bmhq_pkg::FIELD_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bmhq_rsp_if.sv */
// response channel: status, removed value, top value and count with valid/ready
`timescale 1ns / 1ps
`default_nettype none

interface bmhq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [bmhq_pkg::STATUS_W-1:0]       status;
  logic signed [bmhq_pkg::FIELD_W-1:0] removed_value;
  logic signed [bmhq_pkg::FIELD_W-1:0] top_value;
  logic [bmhq_pkg::ENTRY_W-1:0]        entry_count;

  modport source (output valid, output status, output removed_value, output top_value,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input removed_value, input top_value,
                  input entry_count, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bmhq_ctrl.sv */
// sequencing state machine of the heap queue
`timescale 1ns / 1ps
`default_nettype none

module bmhq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  input  wire logic           req_operation,
  output logic                req_ready,
  input  wire bmhq_pkg::sts_t sts,
  output bmhq_pkg::cmd_t      cmd
);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_UP_RD     = 8'b0000_0010,
    S_UP_CMP    = 8'b0000_0100,
    S_LAST_RD   = 8'b0000_1000,
    S_LAST_WAIT = 8'b0001_0000,
    S_DN_RD     = 8'b0010_0000,
    S_DN_CMP    = 8'b0100_0000,
    S_RESP      = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (bmhq_pkg::op_t'(req_operation) == bmhq_pkg::OP_INSERT) begin
            if (sts.full) begin
              cmd.refuse_full = 1'b1;
              state_next      = S_RESP;
            end else begin
              cmd.accept_ins = 1'b1;
              state_next     = S_UP_RD;
            end
          end else begin
            if (sts.empty) begin
              cmd.refuse_empty = 1'b1;
              state_next       = S_RESP;
            end else begin
              cmd.accept_rem = 1'b1;
              state_next     = S_LAST_RD;
            end
          end
        end
      end
      S_UP_RD: begin
        if (sts.pos_zero) begin
          cmd.place  = 1'b1;
          state_next = S_RESP;
        end else begin
          cmd.up_read = 1'b1;
          state_next  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.up_greater) begin
          cmd.up_move = 1'b1;
          state_next  = S_UP_RD;
        end else begin
          cmd.place  = 1'b1;
          state_next = S_RESP;
        end
      end
      S_LAST_RD: begin
        // count already dropped: nothing left to rebalance when it reached zero
        if (sts.empty) begin
          state_next = S_RESP;
        end else begin
          cmd.last_read = 1'b1;
          state_next    = S_LAST_WAIT;
        end
      end
      S_LAST_WAIT: begin
        cmd.last_take = 1'b1;
        state_next    = S_DN_RD;
      end
      S_DN_RD: begin
        if (sts.left_ok) begin
          cmd.dn_read = 1'b1;
          state_next  = S_DN_CMP;
        end else begin
          cmd.place  = 1'b1;
          state_next = S_RESP;
        end
      end
      S_DN_CMP: begin
        if (sts.dn_greater) begin
          cmd.dn_move = 1'b1;
          state_next  = S_DN_RD;
        end else begin
          cmd.place  = 1'b1;
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bmhq_dp.sv */
// heap store, moving entry, hole index, count and result register
`timescale 1ns / 1ps
`default_nettype none

module bmhq_dp #(
  parameter int CAPACITY   = bmhq_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = bmhq_pkg::VALUE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire bmhq_pkg::cmd_t                      cmd,
  output bmhq_pkg::sts_t                           sts,
  input  wire logic signed [bmhq_pkg::FIELD_W-1:0] in_value,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output logic [bmhq_pkg::STATUS_W-1:0]            out_status,
  output logic signed [bmhq_pkg::FIELD_W-1:0]      out_removed_value,
  output logic signed [bmhq_pkg::FIELD_W-1:0]      out_top_value,
  output logic [bmhq_pkg::ENTRY_W-1:0]             out_entry_count
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CH_W  = CNT_W + 1;

  typedef logic signed [VALUE_BITS-1:0] word_t;

  // stored word sign-extended, low field bits kept
  function automatic logic [bmhq_pkg::FIELD_W-1:0] to_field(input word_t w);
    logic signed [63:0] ext;
    ext = 64'(w);
    return ext[bmhq_pkg::FIELD_W-1:0];
  endfunction

  word_t mem [CAPACITY];

  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] pos;
  word_t            moving;
  word_t            top;
  word_t            rd_a, rd_b;
  logic [IDX_W-1:0] ra, rb, waddr;
  logic             we;
  word_t            wdata;

  logic [bmhq_pkg::STATUS_W-1:0] res_status;
  logic [bmhq_pkg::FIELD_W-1:0]  res_removed;

  logic [63:0]      in_wide;
  word_t            in_word;
  logic [IDX_W-1:0] parent;
  logic [CH_W-1:0]  left, right, count_ext;
  logic             right_ok, pick_right;
  word_t            pick_val;
  logic [IDX_W-1:0] pick_idx;

  // input zero-extended, then kept at the store width
  assign in_wide = {{(64 - bmhq_pkg::FIELD_W){1'b0}}, in_value};
  assign in_word = word_t'(in_wide[VALUE_BITS-1:0]);

  assign parent    = IDX_W'((pos - IDX_W'(1)) >> 1);
  assign left      = (CH_W'(pos) << 1) + CH_W'(1);
  assign right     = left + CH_W'(1);
  assign count_ext = CH_W'(count);
  assign right_ok  = right < count_ext;

  // larger child, left on a tie
  assign pick_right = right_ok && (rd_b > rd_a);
  assign pick_val   = pick_right ? rd_b : rd_a;
  assign pick_idx   = pick_right ? right[IDX_W-1:0] : left[IDX_W-1:0];

  assign sts.full       = (count == CNT_W'(CAPACITY));
  assign sts.empty      = (count == '0);
  assign sts.pos_zero   = (pos == '0);
  assign sts.left_ok    = left < count_ext;
  assign sts.up_greater = moving > rd_a;
  assign sts.dn_greater = pick_val > moving;
  assign sts.out_free   = !out_valid || out_ready;

  always_comb begin
    we    = cmd.up_move || cmd.dn_move || cmd.place;
    waddr = pos;
    wdata = moving;
    if (cmd.up_move) begin
      wdata = rd_a;
    end else if (cmd.dn_move) begin
      wdata = pick_val;
    end
    ra = '0;
    rb = '0;
    if (cmd.up_read) begin
      ra = parent;
    end else if (cmd.last_read) begin
      ra = count[IDX_W-1:0];
    end else if (cmd.dn_read) begin
      ra = left[IDX_W-1:0];
      rb = right[IDX_W-1:0];
    end
  end

  // store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.accept_ins) begin
      count <= count + CNT_W'(1);
    end else if (cmd.accept_rem) begin
      count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_ins) begin
      moving <= in_word;
      pos    <= count[IDX_W-1:0];
    end else if (cmd.last_take) begin
      moving <= rd_a;
      pos    <= '0;
    end else if (cmd.up_move) begin
      pos <= parent;
    end else if (cmd.dn_move) begin
      pos <= pick_idx;
    end
    // root copy follows every write to the root
    if (we && waddr == '0) begin
      top <= wdata;
    end
    if (cmd.accept_ins) begin
      res_status  <= bmhq_pkg::STATUS_OK;
      res_removed <= '0;
    end else if (cmd.accept_rem) begin
      res_status  <= bmhq_pkg::STATUS_OK;
      res_removed <= to_field(top);
    end else if (cmd.refuse_full) begin
      res_status  <= bmhq_pkg::STATUS_FULL;
      res_removed <= '0;
    end else if (cmd.refuse_empty) begin
      res_status  <= bmhq_pkg::STATUS_EMPTY;
      res_removed <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status        <= res_status;
      out_removed_value <= res_removed;
      out_top_value     <= sts.empty ? '0 : to_field(top);
      out_entry_count   <= bmhq_pkg::ENTRY_W'(count);
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/binary_max_heap_queue.sv */
// top level of the binary max-heap priority queue
// insert: accept, then per level read the parent and compare, moving the parent down until
//   the root or a parent not smaller; remove: accept, read the last entry, move it to the
//   root unless now empty, then per level read both children and compare; refusals go
//   straight to the result; one item at a time, the next taken once its result is loaded
// reset: synchronous, clears the count, the result valid and the state machine; store left as is
`timescale 1ns / 1ps
`default_nettype none

module binary_max_heap_queue #(
  parameter int CAPACITY   = bmhq_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = bmhq_pkg::VALUE_BITS_DEF
) (
  input wire logic     clk,
  input wire logic     rst,
  bmhq_req_if.sink     req,
  bmhq_rsp_if.source   rsp
);

  // command and status bundles between sequencer and datapath
  bmhq_pkg::cmd_t cmd;
  bmhq_pkg::sts_t sts;

  // input transfer only while the sequencer is idle; the result register
  // keeps the finished item so a new one can start while it waits
  bmhq_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req.valid),
    .req_operation (req.operation),
    .req_ready     (req.ready),
    .sts           (sts),
    .cmd           (cmd)
  );

  // the sift moves a hole instead of swapping: the moving entry is held in a
  // register and written once when it settles, so each level costs one read
  // and at most one write
  bmhq_dp #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .in_value          (req.value),
    .out_ready         (rsp.ready),
    .out_valid         (rsp.valid),
    .out_status        (rsp.status),
    .out_removed_value (rsp.removed_value),
    .out_top_value     (rsp.top_value),
    .out_entry_count   (rsp.entry_count)
  );

endmodule

`default_nettype wire

/* hw/rtl/bmhq_checker.sv */
// port-level checks of the heap queue and their binding to the top level
`timescale 1ns / 1ps
`default_nettype none

module bmhq_checker #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                rsp_valid,
  input wire logic                                rsp_ready,
  input wire logic [bmhq_pkg::STATUS_W-1:0]       rsp_status,
  input wire logic signed [bmhq_pkg::FIELD_W-1:0] rsp_removed_value,
  input wire logic signed [bmhq_pkg::FIELD_W-1:0] rsp_top_value,
  input wire logic [bmhq_pkg::ENTRY_W-1:0]        rsp_entry_count
);

  localparam logic WIDE = (CAPACITY > 127);

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status == bmhq_pkg::STATUS_OK || rsp_status == bmhq_pkg::STATUS_FULL ||
                   rsp_status == bmhq_pkg::STATUS_EMPTY))
    else $error("result status outside the defined codes");

  a_empty_refusal: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status == bmhq_pkg::STATUS_EMPTY) |->
      (rsp_removed_value == '0 && rsp_top_value == '0 && rsp_entry_count == '0))
    else $error("empty refusal reports a value or a count");

  a_full_refusal: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status == bmhq_pkg::STATUS_FULL) |->
      (rsp_removed_value == '0 && (WIDE || rsp_entry_count == bmhq_pkg::ENTRY_W'(CAPACITY))))
    else $error("full refusal with a removed value or a short count");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (WIDE || rsp_entry_count <= bmhq_pkg::ENTRY_W'(CAPACITY)))
    else $error("entry count beyond capacity");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) &&
      $stable(rsp_removed_value) && $stable(rsp_top_value) && $stable(rsp_entry_count)))
    else $error("stalled result changed");

endmodule

bind binary_max_heap_queue bmhq_checker #(
  .CAPACITY (CAPACITY)
) u_bmhq_checker (
  .clk               (clk),
  .rst               (rst),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_removed_value (rsp.removed_value),
  .rsp_top_value     (rsp.top_value),
  .rsp_entry_count   (rsp.entry_count)
);

`default_nettype wire

/* tb/binary_max_heap_queue_tb.sv */
// self-checking testbench of the binary max-heap priority queue
`timescale 1ns / 1ps

module binary_max_heap_queue_tb;
  import bmhq_pkg::*;

  localparam int HEAP_DEPTH = CAPACITY_DEF;
  localparam int STIM_PER_PHASE = 550;

  // one request as queued for the driver
  typedef struct {
    op_t                       op;
    logic signed [FIELD_W-1:0] value;
  } heap_req_t;

  // one response as the heap should produce it
  typedef struct {
    status_t                   status;
    logic signed [FIELD_W-1:0] removed;
    logic signed [FIELD_W-1:0] top;
    logic [ENTRY_W-1:0]        count;
  } heap_result_t;

  logic clk;
  logic rst;

  bmhq_req_if req_ch ();
  bmhq_rsp_if rsp_ch ();

  binary_max_heap_queue #(
    .CAPACITY   (HEAP_DEPTH),
    .VALUE_BITS (VALUE_BITS_DEF)
  ) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // shadow copy of the heap, updated at each accepted request
  logic signed [FIELD_W-1:0] heap_mem [HEAP_DEPTH];
  int                        heap_fill;

  heap_req_t    pending_reqs[$];     // requests waiting for the driver
  heap_result_t expected_results[$]; // predicted responses, oldest first

  // idling knobs, changed between phases while the block is idle
  int burst_max;
  int gap_max;
  int stall_pct;
  int stall_max;

  // bookkeeping
  int error_count;
  int checked_count;
  int insert_count;
  int remove_count;
  int full_refusals;
  int empty_refusals;
  int gen_count;   // entry count as seen by the stimulus generator

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("timeout: %0d requests still queued, %0d responses outstanding",
             pending_reqs.size(), expected_results.size());
    $display("Verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h", $realtime, what, got, want);
    error_count++;
  endtask

  // predicts the response of one operation and updates the shadow heap
  function automatic heap_result_t apply_heap_op(op_t op, logic signed [FIELD_W-1:0] v);
    heap_result_t              r;
    int                        pos;
    int                        up;
    int                        lc;
    int                        pick;
    logic signed [FIELD_W-1:0] t;
    r.status  = STATUS_OK;
    r.removed = '0;
    if (op == OP_INSERT) begin
      if (heap_fill >= HEAP_DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        // append, then climb while strictly greater than the parent
        pos = heap_fill;
        heap_mem[pos] = v;
        heap_fill++;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (heap_mem[pos] > heap_mem[up]) begin
            t = heap_mem[pos];
            heap_mem[pos] = heap_mem[up];
            heap_mem[up] = t;
            pos = up;
          end else begin
            break;
          end
        end
      end
    end else begin
      if (heap_fill == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.removed = heap_mem[0];
        heap_fill--;
        if (heap_fill > 0) begin
          // last entry to the root, then sink toward the larger child
          heap_mem[0] = heap_mem[heap_fill];
          pos = 0;
          while (1) begin
            lc = 2 * pos + 1;
            if (lc >= heap_fill) break;
            pick = lc;
            // left child wins a tie
            if (lc + 1 < heap_fill && heap_mem[lc + 1] > heap_mem[lc]) pick = lc + 1;
            if (heap_mem[pick] > heap_mem[pos]) begin
              t = heap_mem[pick];
              heap_mem[pick] = heap_mem[pos];
              heap_mem[pos] = t;
              pos = pick;
            end else begin
              break;
            end
          end
        end
      end
    end
    r.top   = (heap_fill > 0) ? heap_mem[0] : '0;
    r.count = ENTRY_W'(heap_fill);
    return r;
  endfunction

  // request driver: bursts of transfers separated by random gaps
  always @(posedge clk) begin : req_driver
    int           burst_left;
    int           gap_left;
    heap_result_t res;
    if (rst) begin
      req_ch.valid     <= 1'b0;
      req_ch.operation <= OP_INSERT;
      req_ch.value     <= '0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        // transfer taken: predict from what was actually on the bus
        res = apply_heap_op(op_t'(req_ch.operation), req_ch.value);
        expected_results.insert(expected_results.size(), res);
        void'(pending_reqs.pop_front());
        if (req_ch.operation == OP_INSERT) begin
          insert_count++;
          if (res.status == STATUS_FULL) full_refusals++;
        end else begin
          remove_count++;
          if (res.status == STATUS_EMPTY) empty_refusals++;
        end
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, burst_max);
          gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        end else begin
          burst_left--;
        end
      end
      if (req_ch.valid && !req_ch.ready) begin
        // hold the offered request until it is taken
      end else if (gap_left > 0 || pending_reqs.size() == 0) begin
        req_ch.valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        req_ch.valid     <= 1'b1;
        req_ch.operation <= pending_reqs[0].op;
        req_ch.value     <= pending_reqs[0].value;
      end
    end
  end

  // response monitor and receiver stall pattern
  always @(posedge clk) begin : rsp_monitor
    int           run_left;
    logic         ready_level;
    heap_result_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      run_left    = 0;
      ready_level = 1'b1;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected response (count)", 32'(rsp_ch.entry_count), '0);
        end else begin
          want = expected_results.pop_front();
          checked_count++;
          if (rsp_ch.status !== want.status)
            report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
          if (rsp_ch.removed_value !== want.removed)
            report_mismatch("removed_value", rsp_ch.removed_value, want.removed);
          if (rsp_ch.top_value !== want.top)
            report_mismatch("top_value", rsp_ch.top_value, want.top);
          if (rsp_ch.entry_count !== want.count)
            report_mismatch("entry_count", 32'(rsp_ch.entry_count), 32'(want.count));
        end
      end
      // runs of ready high or low, lengths drawn at random
      if (run_left > 0) begin
        run_left--;
      end else begin
        ready_level = (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
        run_left    = $urandom_range(0, stall_max);
      end
      rsp_ch.ready <= ready_level;
    end
  end

  // value mix: full range, a narrow band for ties, and the extremes
  function automatic logic signed [FIELD_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5:       return $signed($urandom_range(0, 8)) - 4;
      6:          return {1'b0, {(FIELD_W - 1){1'b1}}};
      7:          return {1'b1, {(FIELD_W - 1){1'b0}}};
      8:          return {1'b0, {(FIELD_W - 1){1'b1}}} - $urandom_range(0, 3);
      default:    return {1'b1, {(FIELD_W - 1){1'b0}}} + $urandom_range(0, 3);
    endcase
  endfunction

  task automatic add_req(input op_t op, input logic signed [FIELD_W-1:0] v);
    heap_req_t r;
    r.op    = op;
    r.value = v;
    pending_reqs.insert(pending_reqs.size(), r);
    if (op == OP_INSERT && gen_count < HEAP_DEPTH) gen_count++;
    if (op == OP_REMOVE && gen_count > 0) gen_count--;
  endtask

  // random sequences: fill to full, drain to empty, or mixed traffic
  task automatic add_random_phase(input int budget);
    int added;
    int n;
    int ins_pct;
    added = 0;
    while (added < budget) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          // climb to full and push a few refused inserts
          n = HEAP_DEPTH - gen_count + $urandom_range(0, 3);
          repeat (n) add_req(OP_INSERT, pick_value());
        end
        2, 3: begin
          // drain to empty and poke the empty heap
          n = gen_count + $urandom_range(0, 3);
          repeat (n) add_req(OP_REMOVE, $urandom);
        end
        default: begin
          n = $urandom_range(10, 40);
          ins_pct = $urandom_range(30, 70);
          repeat (n) begin
            if ($urandom_range(0, 99) < ins_pct) add_req(OP_INSERT, pick_value());
            else add_req(OP_REMOVE, $urandom);
          end
        end
      endcase
      added += n;
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(input int bmax, input int gmax, input int spct, input int smax);
    burst_max = bmax;
    gap_max   = gmax;
    stall_pct = spct;
    stall_max = smax;
  endtask

  initial begin
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.operation = OP_INSERT;
    req_ch.value     = '0;
    rsp_ch.ready     = 1'b0;
    heap_fill        = 0;
    error_count      = 0;
    checked_count    = 0;
    insert_count     = 0;
    remove_count     = 0;
    full_refusals    = 0;
    empty_refusals   = 0;
    gen_count        = 0;
    set_idling(1, 0, 0, 0);
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: empty remove, extreme values, ordering and ties
    add_req(OP_REMOVE, $urandom);
    add_req(OP_INSERT, {1'b0, {(FIELD_W - 1){1'b1}}});
    add_req(OP_INSERT, {1'b1, {(FIELD_W - 1){1'b0}}});
    add_req(OP_INSERT, '0);
    add_req(OP_INSERT, -1);
    add_req(OP_INSERT, 1);
    repeat (5) add_req(OP_REMOVE, $urandom);
    add_req(OP_REMOVE, $urandom);
    // equal children: the left one should be kept on a tie
    add_req(OP_INSERT, 5);
    add_req(OP_INSERT, 5);
    add_req(OP_INSERT, 5);
    add_req(OP_INSERT, 3);
    add_req(OP_INSERT, 9);
    add_req(OP_REMOVE, $urandom);
    // right child larger than the left one
    add_req(OP_INSERT, 2);
    add_req(OP_INSERT, 7);
    repeat (6) add_req(OP_REMOVE, $urandom);
    wait_drained();

    // random traffic under three idling profiles
    set_idling(6, 8, 40, 10);
    add_random_phase(STIM_PER_PHASE);
    wait_drained();

    set_idling(1, 0, 0, 0);
    add_random_phase(STIM_PER_PHASE);
    wait_drained();

    set_idling(20, 3, 20, 4);
    add_random_phase(STIM_PER_PHASE);
    wait_drained();

    // let any stray response show up
    repeat (40) @(posedge clk);

    $display("covered %0d inserts (%0d refused as full) and %0d removes (%0d refused as empty)",
             insert_count, full_refusals, remove_count, empty_refusals);
    $display("%0d responses checked, %0d mismatches", checked_count, error_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
